/* hw/rtl/tma_pkg.sv */
package tma_pkg;

    localparam int ElementWidthDefault = 32;
    localparam int SatWidthMax = 32;

    localparam logic [2:0] CMD_IDENTITY = 3'd0;
    localparam logic [2:0] CMD_ZERO     = 3'd1;
    localparam logic [2:0] CMD_TRANS    = 3'd2;
    localparam logic [2:0] CMD_ROT_X    = 3'd3;
    localparam logic [2:0] CMD_ROT_Y    = 3'd4;
    localparam logic [2:0] CMD_ROT_Z    = 3'd5;
    localparam logic [2:0] CMD_READ     = 3'd6;
    localparam logic [2:0] CMD_UNUSED   = 3'd7;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;

    localparam int InDataWidth = 120;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] shift_x;
        logic [31:0] shift_y;
        logic [31:0] shift_z;
        logic [15:0] angle;
    } cmd_t;

endpackage

/* hw/rtl/tma_front.sv */
module tma_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [119:0]          s_tdata,
    output logic                  q_valid,
    input  logic                  q_ready,
    output tma_pkg::cmd_t         q_cmd
);
    import tma_pkg::*;

    localparam int Depth = 2;

    cmd_t       fifo_reg [Depth];
    logic [0:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    cmd_t       in_cmd;

    assign in_cmd.command = s_tdata[2:0];
    assign in_cmd.shift_x = s_tdata[34:3];
    assign in_cmd.shift_y = s_tdata[66:35];
    assign in_cmd.shift_z = s_tdata[98:67];
    assign in_cmd.angle   = s_tdata[114:99];

    assign s_tready = (count_reg != 2'(Depth));
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = fifo_reg[rd_ptr_reg];
    // unused command codes are dropped here
    assign push = s_tvalid && s_tready && (in_cmd.command != CMD_UNUSED);
    assign pop  = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + 1'b1;
        rd_ptr_next = rd_ptr_reg + 1'b1;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_next;
            if (pop) rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
        if (push) fifo_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

/* hw/rtl/tma_sincos.sv */
module tma_sincos (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] angle,
    output logic               done,
    output logic signed [31:0] sin_q16,
    output logic signed [31:0] cos_q16
);
    import tma_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RED  = 4'd1;
    localparam logic [3:0] ST_X2   = 4'd2;
    localparam logic [3:0] ST_MUL  = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_SMUL = 4'd5;
    localparam logic [3:0] ST_OUT  = 4'd6;

    logic [3:0]  state_reg;
    logic        aneg_reg;
    logic [33:0] u_reg;
    logic [1:0]  k_reg;
    logic        rneg_reg;
    logic [30:0] x_reg, x2_reg, t_reg, prod_reg, s_reg;
    logic [2:0]  step_reg;
    logic        phase_reg;
    logic [30:0] c_reg;

    logic [61:0] mul_full;
    logic [30:0] mul_a, mul_b;
    logic [31:0] recip;
    logic [5:0]  rshift;
    logic [62:0] div_full;
    logic [30:0] quot;
    logic signed [35:0] r_val;
    logic [33:0] kk;

    assign mul_full = mul_a * mul_b;

    always_comb begin
        mul_a = x2_reg;
        mul_b = t_reg;
        case (state_reg)
            ST_X2:   begin mul_a = x_reg; mul_b = x_reg; end
            ST_SMUL: begin mul_a = x_reg; mul_b = t_reg; end
            default: begin mul_a = x2_reg; mul_b = t_reg; end
        endcase
    end

    // division by a small constant as multiply by ceil(2^s/d), exact for 31-bit operands
    always_comb begin
        case ({phase_reg, step_reg})
            4'b0000: begin recip = 32'd3817748708; rshift = 6'd38; end
            4'b0001: begin recip = 32'd3272356036; rshift = 6'd37; end
            4'b0010: begin recip = 32'd3435973837; rshift = 6'd36; end
            4'b0011: begin recip = 32'd2863311531; rshift = 6'd34; end
            4'b1000: begin recip = 32'd3054198967; rshift = 6'd38; end
            4'b1001: begin recip = 32'd2454267027; rshift = 6'd37; end
            4'b1010: begin recip = 32'd2290649225; rshift = 6'd36; end
            4'b1011: begin recip = 32'd2863311531; rshift = 6'd35; end
            default: begin recip = 32'h8000_0000; rshift = 6'd32; end
        endcase
    end
    assign div_full = 63'(prod_reg) * 63'(recip);
    assign quot     = 31'(div_full >> rshift);

    // nearest quadrant count: u <= 2^33, so k is at most 5
    always_comb begin
        kk = 34'd0;
        for (int i = 1; i < 6; i++) begin
            if (u_reg + 34'(HALF_PI_Q30 >> 1) >= 34'(i) * 34'(HALF_PI_Q30))
                kk = 34'(i);
        end
        r_val = $signed({2'b00, u_reg}) - $signed({2'b00, kk * 34'(HALF_PI_Q30)});
    end

    function automatic logic [31:0] to_q16(input logic [30:0] mag, input logic neg);
        logic [31:0] q;
        q = 32'((mag + 31'd8192) >> 14);
        return neg ? -q : q;
    endfunction

    logic sn, cn;
    logic [30:0] smag, cmag;
    always_comb begin
        case (k_reg)
            2'd0: begin smag = s_reg; sn = rneg_reg;  cmag = c_reg; cn = 1'b0;  end
            2'd1: begin smag = c_reg; sn = 1'b0;      cmag = s_reg; cn = !rneg_reg; end
            2'd2: begin smag = s_reg; sn = !rneg_reg; cmag = c_reg; cn = 1'b1;  end
            default: begin smag = c_reg; sn = 1'b1;   cmag = s_reg; cn = rneg_reg; end
        endcase
    end

    assign done = (state_reg == ST_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: if (start) state_reg <= ST_RED;
                ST_RED:  state_reg <= ST_X2;
                ST_X2: begin
                    state_reg <= ST_DIV;
                end
                ST_MUL: state_reg <= ST_DIV;
                ST_DIV: begin
                    if (step_reg == 3'd4 || (phase_reg == 1'b0 && step_reg == 3'd3)) begin
                        state_reg <= (phase_reg == 1'b0) ? ST_SMUL : ST_OUT;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_SMUL: state_reg <= ST_DIV;
                ST_OUT:  state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
        case (state_reg)
            ST_IDLE: begin
                aneg_reg <= angle[15];
                u_reg    <= {2'b00, (angle[15] ? 16'(-angle) : angle), 16'd0} << 2;
            end
            ST_RED: begin
                k_reg    <= kk[1:0];
                rneg_reg <= r_val[35];
                x_reg    <= 31'(r_val[35] ? -r_val : r_val);
            end
            ST_X2: begin
                x2_reg    <= 31'(mul_full >> 30);
                prod_reg  <= 31'(mul_full >> 30);
                step_reg  <= 3'd0;
                phase_reg <= 1'b0;
            end
            ST_MUL: prod_reg <= 31'(mul_full >> 30);
            ST_DIV: begin
                t_reg    <= ONE_Q30 - quot;
                step_reg <= step_reg + 3'd1;
                if (phase_reg == 1'b1 && step_reg == 3'd4) c_reg <= ONE_Q30 - quot;
            end
            ST_SMUL: begin
                s_reg     <= 31'(mul_full >> 30);
                phase_reg <= 1'b1;
                step_reg  <= 3'd0;
                prod_reg  <= x2_reg;
            end
            ST_OUT: begin
                sin_q16 <= to_q16(smag, sn ^ aneg_reg);
                cos_q16 <= to_q16(cmag, cn);
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/tma_back.sv */
module tma_back #(
    parameter int ELEMENT_WIDTH = tma_pkg::ElementWidthDefault
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  tma_pkg::cmd_t             q_cmd,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [39:0]               m_tdata,
    output logic                      m_tlast
);
    import tma_pkg::*;

    localparam int SatW = (ELEMENT_WIDTH > SatWidthMax) ? SatWidthMax : ELEMENT_WIDTH;
    localparam logic signed [63:0] SatHi = (64'sd1 <<< (SatW - 1)) - 64'sd1;
    localparam logic signed [63:0] SatLo = -SatHi - 64'sd1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TRIG = 3'd1;
    localparam logic [2:0] ST_MAC  = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;

    logic [2:0]  state_reg;
    cmd_t        cmd_reg;
    logic signed [31:0] mat_reg [16];
    logic signed [31:0] sin_v, cos_v;
    logic        trig_start, trig_done;
    logic [4:0]  step_reg;
    logic [4:0]  idx_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;

    logic signed [31:0] fa, fb;
    logic [3:0]  ea;
    logic        first_term, last_term, add_plain;
    logic [3:0]  dst;
    logic [1:0]  p, qc;

    tma_sincos u_sincos (
        .aclk(aclk), .aresetn(aresetn), .start(trig_start), .angle(cmd_reg.angle),
        .done(trig_done), .sin_q16(sin_v), .cos_q16(cos_v)
    );

    assign trig_start = (state_reg == ST_TRIG) && !trig_done;
    assign q_ready = (state_reg == ST_IDLE);

    function automatic logic signed [63:0] sat(input logic signed [63:0] v);
        if (v > SatHi) return SatHi;
        if (v < SatLo) return SatLo;
        return v;
    endfunction

    // term sequencing: each output element is two (rotate) or four (translate) terms
    always_comb begin
        p  = 2'd0; qc = 2'd1;
        case (cmd_reg.command)
            CMD_ROT_X: begin p = 2'd1; qc = 2'd2; end
            CMD_ROT_Y: begin p = 2'd0; qc = 2'd2; end
            default:   begin p = 2'd0; qc = 2'd1; end
        endcase
        fa = 32'sd0; ea = 4'd0; dst = 4'd0; add_plain = 1'b0;
        first_term = 1'b0; last_term = 1'b0;
        if (cmd_reg.command == CMD_TRANS) begin
            dst = {2'd3, step_reg[3:2]};
            first_term = (step_reg[1:0] == 2'd0);
            last_term  = (step_reg[1:0] == 2'd3);
            ea = {step_reg[1:0], step_reg[3:2]};
            case (step_reg[1:0])
                2'd0: fa = cmd_reg.shift_x;
                2'd1: fa = cmd_reg.shift_y;
                2'd2: fa = cmd_reg.shift_z;
                default: begin fa = 32'sd0; add_plain = 1'b1; end
            endcase
        end else begin
            // step[3:2]=row, step[1]=target column (p then q), step[0]=term
            first_term = (step_reg[0] == 1'b0);
            last_term  = (step_reg[0] == 1'b1);
            ea = {(step_reg[0] ? qc : p), step_reg[3:2]};
            dst = {(step_reg[1] ? qc : p), step_reg[3:2]};
            case ({cmd_reg.command == CMD_ROT_Y, step_reg[1], step_reg[0]})
                3'b000: fa = cos_v;
                3'b001: fa = sin_v;
                3'b010: fa = -sin_v;
                3'b011: fa = cos_v;
                3'b100: fa = cos_v;
                3'b101: fa = -sin_v;
                3'b110: fa = sin_v;
                default: fa = cos_v;
            endcase
        end
    end
    assign fb = mat_reg[ea];

    logic signed [63:0] term_v;
    assign term_v = add_plain ? 64'(fb) : ((64'(fa) * 64'(fb) + 64'sd32768) >>> 16);

    logic rd_go;
    assign rd_go = !m_tvalid || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_tvalid  <= 1'b0;
            for (int i = 0; i < 16; i++) mat_reg[i] <= '0;
        end else begin
            if (m_tvalid && m_tready && state_reg != ST_READ) m_tvalid <= 1'b0;
            case (state_reg)
                ST_IDLE: if (q_valid) begin
                    cmd_reg  <= q_cmd;
                    step_reg <= '0;
                    idx_reg  <= '0;
                    case (q_cmd.command)
                        CMD_IDENTITY: for (int i = 0; i < 16; i++)
                            mat_reg[i] <= (i % 5 == 0) ? 32'(sat(64'sd65536)) : 32'sd0;
                        CMD_ZERO: for (int i = 0; i < 16; i++) mat_reg[i] <= '0;
                        CMD_TRANS: state_reg <= ST_MAC;
                        CMD_READ:  state_reg <= ST_READ;
                        CMD_ROT_X, CMD_ROT_Y, CMD_ROT_Z: state_reg <= ST_TRIG;
                        default: ;
                    endcase
                end
                ST_TRIG: if (trig_done) state_reg <= ST_MAC;
                ST_MAC: begin
                    // rotation: stage the p-column result, write it with the q-column result after both
                    acc_reg <= first_term ? term_v : acc_reg + term_v;
                    if (last_term) begin
                        if (cmd_reg.command == CMD_TRANS) begin
                            mat_reg[dst] <= 32'(sat(acc_reg + term_v));
                        end else if (step_reg[1] == 1'b0) begin
                            prod_reg <= sat(acc_reg + term_v);
                        end else begin
                            mat_reg[{p, step_reg[3:2]}] <= 32'(prod_reg);
                            mat_reg[dst] <= 32'(sat(acc_reg + term_v));
                        end
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd15) state_reg <= ST_WAIT;
                end
                ST_READ: if (rd_go) begin
                    m_tvalid <= 1'b1;
                    m_tdata  <= {4'd0, mat_reg[idx_reg[3:0]], idx_reg[3:0]};
                    m_tlast  <= (idx_reg == 5'd15);
                    idx_reg  <= idx_reg + 5'd1;
                    if (idx_reg == 5'd15) state_reg <= ST_WAIT;
                end
                ST_WAIT: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/transform_matrix_accumulator_core.sv */
// channel | beat fields (low bit up)                           | dir
// s_axis  | command[2:0] shift_x shift_y shift_z angle[15:0]     | in
// m_axis  | element_index[3:0] element_value[31:0], tlast=last   | out
// Back end, from dequeue: identity and zero are applied at dequeue; translate
// runs 16 MACs, 4 per column-3 element; rotate runs the serial sine/cosine,
// then 16 MACs. Reads send 16 beats to the output, one per cycle while
// m_tready holds. Synchronous active-low reset clears the matrix to zero and
// empties the queue. A two-entry command queue lets the input side accept
// while results stall.
module transform_matrix_accumulator_core #(
    parameter int ELEMENT_WIDTH = tma_pkg::ElementWidthDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,   // command, shift_x, shift_y, shift_z, angle
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // element_index, element_value
    output logic         m_tlast
);
    import tma_pkg::*;

    logic q_valid, q_ready;
    cmd_t q_cmd;

    tma_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    tma_back #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[3:0] == 4'd15)
        else $error("last beat not element 15");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:36] == 4'd0)
        else $error("padding bits nonzero");

endmodule

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tma_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;   // command, shift_x, shift_y, shift_z, angle
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;   // element_index, element_value
    logic         m_tlast;

    transform_matrix_accumulator_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    typedef struct packed {
        logic [3:0]  index;
        logic [31:0] value;
        logic        last;
    } element_t;

    typedef struct {
        logic [2:0]  command;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
        logic [15:0] angle;
        bit          has_value;
        logic [31:0] value15;
    } row_t;

    longint   model[16];
    element_t pending_elements[$];
    int       error_count;
    longint   cycle_count;
    bit       sender_busy;

    localparam longint HalfPi = 64'd1686629713;
    localparam longint OneQ30 = 64'd1 << 30;
    localparam longint CycleLimit = 64'd2000000;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return fshift(a * b + 32768, 16);
    endfunction

    function automatic longint umul30(longint a, longint b);
        longint unsigned p;
        p = longint'(a) * longint'(b);
        return longint'(p >> 30);
    endfunction

    function automatic longint q16_of(longint mag, bit neg);
        longint q;
        q = (mag + 8192) >> 14;
        return neg ? -q : q;
    endfunction

    task automatic sine_cosine(input logic [15:0] ang, output longint sv, output longint cv);
        longint a, u, k, r, x, x2, t, s, c, smag, cmag;
        bit aneg, rneg, sn, cn;
        a = longint'($signed(ang));
        aneg = a < 0;
        u = (aneg ? -a : a) << 18;
        k = (u + HalfPi / 2) / HalfPi;
        r = u - k * HalfPi;
        rneg = r < 0;
        x = rneg ? -r : r;
        x2 = umul30(x, x);
        t = OneQ30 - x2 / 72;
        t = OneQ30 - umul30(x2, t) / 42;
        t = OneQ30 - umul30(x2, t) / 20;
        t = OneQ30 - umul30(x2, t) / 6;
        s = umul30(x, t);
        t = OneQ30 - x2 / 90;
        t = OneQ30 - umul30(x2, t) / 56;
        t = OneQ30 - umul30(x2, t) / 30;
        t = OneQ30 - umul30(x2, t) / 12;
        c = OneQ30 - umul30(x2, t) / 2;
        case (k & 3)
            0: begin smag = s; sn = rneg;  cmag = c; cn = 1'b0;  end
            1: begin smag = c; sn = 1'b0;  cmag = s; cn = !rneg; end
            2: begin smag = s; sn = !rneg; cmag = c; cn = 1'b1;  end
            default: begin smag = c; sn = 1'b1; cmag = s; cn = rneg; end
        endcase
        if (aneg) sn = !sn;
        sv = q16_of(smag, sn);
        cv = q16_of(cmag, cn);
    endtask

    task automatic mix_columns(int p, int q, longint a, longint b, longint d, longint e);
        longint mp, mq;
        for (int row = 0; row < 4; row++) begin
            mp = model[p * 4 + row];
            mq = model[q * 4 + row];
            model[p * 4 + row] = clamp32(fx_mul(a, mp) + fx_mul(b, mq));
            model[q * 4 + row] = clamp32(fx_mul(d, mp) + fx_mul(e, mq));
        end
    endtask

    task automatic apply_command(input logic [119:0] beat);
        logic [2:0] cmd;
        longint tx, ty, tz, sv, cv, v;
        element_t el;
        cmd = beat[2:0];
        tx = longint'($signed(beat[34:3]));
        ty = longint'($signed(beat[66:35]));
        tz = longint'($signed(beat[98:67]));
        sine_cosine(beat[114:99], sv, cv);
        case (cmd)
            CMD_IDENTITY: for (int i = 0; i < 16; i++) model[i] = (i % 5 == 0) ? 65536 : 0;
            CMD_ZERO:     for (int i = 0; i < 16; i++) model[i] = 0;
            CMD_TRANS: begin
                for (int i = 0; i < 4; i++) begin
                    v = fx_mul(tx, model[i]) + fx_mul(ty, model[4 + i])
                      + fx_mul(tz, model[8 + i]) + model[12 + i];
                    model[12 + i] = clamp32(v);
                end
            end
            CMD_ROT_X: mix_columns(1, 2, cv, sv, -sv, cv);
            CMD_ROT_Y: mix_columns(0, 2, cv, -sv, sv, cv);
            CMD_ROT_Z: mix_columns(0, 1, cv, sv, -sv, cv);
            CMD_READ: begin
                for (int i = 0; i < 16; i++) begin
                    el.index = 4'(i);
                    el.value = model[i][31:0];
                    el.last = (i == 15);
                    pending_elements.push_back(el);
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic logic [119:0] pack_beat(logic [2:0] c, logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z, logic [15:0] a);
        return {5'd0, a, z, y, x, c};
    endfunction

    // one beat on the input channel, with bursty gaps
    int burst_left;
    task automatic send_beat(input logic [119:0] beat);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata <= beat;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_command(beat);
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_elements.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // receiver stall pattern
    int stall_mode;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    element_t got_el, want_el;
    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn && m_tvalid && m_tready) begin
            got_el.index = m_tdata[3:0];
            got_el.value = m_tdata[35:4];
            got_el.last = m_tlast;
            if (pending_elements.size() == 0) begin
                report_mismatch("unexpected beat", {28'd0, got_el.index}, 32'd0);
            end else begin
                want_el = pending_elements.pop_front();
                if (got_el.index !== want_el.index)
                    report_mismatch("index", {28'd0, got_el.index}, {28'd0, want_el.index});
                if (got_el.value !== want_el.value)
                    report_mismatch("value", got_el.value, want_el.value);
                if (got_el.last !== want_el.last)
                    report_mismatch("tlast", {31'd0, got_el.last}, {31'd0, want_el.last});
                if (m_tdata[39:36] !== 4'd0)
                    report_mismatch("pad", {28'd0, m_tdata[39:36]}, 32'd0);
            end
        end
        if (cycle_count > CycleLimit) begin
            $display("timeout");
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_shift();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
        endcase
    endfunction

    row_t directed[$];
    row_t rw;
    logic [2:0] rc;
    logic [119:0] want_beat;

    initial begin
        error_count = 0;
        cycle_count = 0;
        burst_left = 0;
        stall_mode = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        for (int i = 0; i < 16; i++) model[i] = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // command, sx, sy, sz, angle, typed check of element 15
        directed = '{
            '{CMD_READ, 0, 0, 0, 0, 1, 32'd0},
            '{CMD_IDENTITY, 0, 0, 0, 0, 0, 0},
            '{CMD_READ, 0, 0, 0, 0, 1, 32'h0001_0000},
            '{CMD_TRANS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 0, 0},
            '{CMD_READ, 0, 0, 0, 0, 0, 0},
            '{CMD_TRANS, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0},
            '{CMD_READ, 0, 0, 0, 0, 0, 0},
            '{CMD_IDENTITY, 0, 0, 0, 0, 0, 0},
            '{CMD_ROT_X, 0, 0, 0, 16'h7FFF, 0, 0},
            '{CMD_ROT_Y, 0, 0, 0, 16'h8000, 0, 0},
            '{CMD_ROT_Z, 0, 0, 0, 16'h1922, 0, 0},
            '{CMD_ROT_Z, 0, 0, 0, 16'hFFFF, 0, 0},
            '{CMD_READ, 0, 0, 0, 0, 0, 0},
            '{CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, 0},
            '{CMD_TRANS, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0},
            '{CMD_READ, 0, 0, 0, 0, 0, 0},
            '{CMD_ZERO, 0, 0, 0, 0, 0, 0},
            '{CMD_READ, 0, 0, 0, 0, 1, 32'd0}
        };
        foreach (directed[i]) begin
            rw = directed[i];
            want_beat = pack_beat(rw.command, rw.sx, rw.sy, rw.sz, rw.angle);
            send_beat(want_beat);
            if (rw.has_value && pending_elements.size() != 0 &&
                    pending_elements[$].value !== rw.value15)
                report_mismatch("predictor", pending_elements[$].value, rw.value15);
        end
        drain_results();

        for (int n = 0; n < 280; n++) begin
            if (n == 140) drain_results();
            case ($urandom_range(0, 19))
                0:       rc = CMD_IDENTITY;
                1:       rc = CMD_ZERO;
                2, 3, 4: rc = CMD_TRANS;
                5, 6:    rc = CMD_ROT_X;
                7, 8:    rc = CMD_ROT_Y;
                9, 10:   rc = CMD_ROT_Z;
                11:      rc = CMD_UNUSED;
                default: rc = CMD_READ;
            endcase
            if (rc == CMD_READ && $urandom_range(0, 1)) rc = CMD_ROT_Z;
            send_beat(pack_beat(rc, rand_shift(), rand_shift(), rand_shift(), 16'($urandom())));
        end
        s_tvalid <= 1'b0;
        while (pending_elements.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

/* files.f */
hw/rtl/tma_pkg.sv
hw/rtl/tma_front.sv
hw/rtl/tma_sincos.sv
hw/rtl/tma_back.sv
hw/rtl/transform_matrix_accumulator_core.sv
bench/testbench.sv
